// File: hw/rtl/rddp_pkg.sv
// Shared constants, types and helpers for the register dependency distance profiler.
// No dependencies.
package rddp_pkg;

    localparam int NUM_REGS = 256;
    localparam int NUM_BINS = 64;
    localparam int MAX_SRCS = 4;
    localparam int MAX_DSTS = 2;

    localparam int REG_W  = 8;
    localparam int BIN_W  = 6;
    localparam int SEQ_W  = 48;
    localparam int CNT_W  = 32;
    localparam int SLOT_W = $clog2(NUM_REGS);
    localparam int NB_W   = $clog2(NUM_BINS);
    localparam int HIDX_W = $clog2(3 * NUM_BINS);
    localparam int QDEPTH = 2;

    localparam int SMAX = (MAX_SRCS < 4) ? MAX_SRCS : 4;
    localparam int DMAX = (MAX_DSTS < 2) ? MAX_DSTS : 2;

    localparam logic [1:0] KIND_RAW = 2'd0;
    localparam logic [1:0] KIND_WAR = 2'd1;
    localparam logic [1:0] KIND_WAW = 2'd2;

    localparam logic CMD_RECORD = 1'b0;
    localparam logic CMD_READ   = 1'b1;

    // Input item
    typedef struct packed {
        logic             cmd;
        logic [2:0]       src_count;
        logic [REG_W-1:0] src_reg_0;
        logic [REG_W-1:0] src_reg_1;
        logic [REG_W-1:0] src_reg_2;
        logic [REG_W-1:0] src_reg_3;
        logic [1:0]       dst_count;
        logic [REG_W-1:0] dst_reg_0;
        logic [REG_W-1:0] dst_reg_1;
        logic [1:0]       hist_kind;
        logic [BIN_W-1:0] hist_bin;
    } in_item_t;

    typedef struct packed {
        logic [CNT_W-1:0] bin_count;
    } out_item_t;

    // Classified operation handed from front to back
    typedef struct packed {
        logic              is_read;
        logic              kind_bad;
        logic [1:0]        kind;
        logic [NB_W-1:0]   bin;
        logic [2:0]        nsrc;
        logic [1:0]        ndst;
        logic [3:0][SLOT_W-1:0] src;
        logic [1:0][SLOT_W-1:0] dst;
    } op_t;

    function automatic logic [SLOT_W-1:0] reg_slot(input logic [REG_W-1:0] id);
        logic [REG_W+SLOT_W-1:0] wide;
        wide = {{SLOT_W{1'b0}}, id};
        return wide[SLOT_W-1:0];
    endfunction

endpackage

// File: hw/rtl/rddp_stream_if.sv
// Valid/ready channel interface carrying one payload type.
// Depends on rddp_pkg for nothing; payload type is a type parameter.
interface rddp_stream_if #(parameter type payload_t = logic);
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// File: hw/rtl/rddp_front.sv
// Front end: accepts items, clamps counts, maps ids to slots and bins.
// Depends on rddp_pkg.
module rddp_front (
    input  logic            clk,
    input  logic            rst_n,
    rddp_stream_if.sink     in_ch,
    output logic            op_valid,
    output rddp_pkg::op_t   op_data,
    input  logic            op_ready
);
    import rddp_pkg::*;

    logic [2:0] ns;
    logic [1:0] nd;
    logic [BIN_W-1:0] bmax;

    // Straight-through classification; queue provides the register
    assign bmax = BIN_W'(NUM_BINS - 1);
    always_comb
    begin
        ns = (in_ch.data.src_count > 3'(SMAX)) ? 3'(SMAX) : in_ch.data.src_count;
        nd = (in_ch.data.dst_count > 2'(DMAX)) ? 2'(DMAX) : in_ch.data.dst_count;
        op_data.is_read  = (in_ch.data.cmd == CMD_READ);
        op_data.kind_bad = (in_ch.data.hist_kind != KIND_RAW) &&
                           (in_ch.data.hist_kind != KIND_WAR) &&
                           (in_ch.data.hist_kind != KIND_WAW);
        op_data.kind     = in_ch.data.hist_kind;
        op_data.bin      = NB_W'((in_ch.data.hist_bin > bmax) ? bmax : in_ch.data.hist_bin);
        op_data.nsrc     = ns;
        op_data.ndst     = nd;
        op_data.src[0]   = reg_slot(in_ch.data.src_reg_0);
        op_data.src[1]   = reg_slot(in_ch.data.src_reg_1);
        op_data.src[2]   = reg_slot(in_ch.data.src_reg_2);
        op_data.src[3]   = reg_slot(in_ch.data.src_reg_3);
        op_data.dst[0]   = reg_slot(in_ch.data.dst_reg_0);
        op_data.dst[1]   = reg_slot(in_ch.data.dst_reg_1);
    end

    assign op_valid    = in_ch.valid && rst_n;
    assign in_ch.ready = op_ready && rst_n;

    logic unused_clk;
    assign unused_clk = clk;
endmodule

// File: hw/rtl/rddp_queue.sv
// Short FIFO of classified operations between front and back.
// Depends on rddp_pkg.
module rddp_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          wr_valid,
    input  rddp_pkg::op_t wr_data,
    output logic          wr_ready,
    output logic          rd_valid,
    output rddp_pkg::op_t rd_data,
    input  logic          rd_ready
);
    import rddp_pkg::*;

    op_t        mem_reg [QDEPTH];
    logic       wp_reg, rp_reg;
    logic [1:0] cnt_reg;
    logic       do_wr, do_rd;

    assign wr_ready = (cnt_reg != 2'(QDEPTH));
    assign rd_valid = (cnt_reg != 2'd0);
    assign rd_data  = mem_reg[rp_reg];
    assign do_wr    = wr_valid && wr_ready;
    assign do_rd    = rd_valid && rd_ready;

    // Storage
    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wp_reg] <= wr_data;
        end
    end

    // Pointers and fill
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (do_wr) wp_reg <= ~wp_reg;
            if (do_rd) rp_reg <= ~rp_reg;
            cnt_reg <= cnt_reg + 2'(do_wr) - 2'(do_rd);
        end
    end
endmodule

// File: hw/rtl/rddp_back.sv
// Back end: sequencer over history and histogram memories, with clearing pass.
// Depends on rddp_pkg.
module rddp_back (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          op_valid,
    input  rddp_pkg::op_t op_data,
    output logic          op_ready,
    rddp_stream_if.source out_ch
);
    import rddp_pkg::*;

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_HRD, S_HWAIT, S_HUPD, S_BRD, S_BWAIT, S_BWR, S_NEXT,
        S_RRD, S_RWAIT, S_RDONE
    } state_t;

    // History and histogram memories
    logic [SEQ_W-1:0] wr_mem [NUM_REGS];
    logic [SEQ_W-1:0] rd_mem [NUM_REGS];
    logic [CNT_W-1:0] h_mem  [3*NUM_BINS];

    state_t           state_reg;
    op_t              op_reg;
    logic [SEQ_W-1:0] seq_reg;
    logic [2:0]       step_reg;   // 0..3 sources, 4..5 destinations
    logic [1:0]       pend_reg;   // pending histogram kinds bitmap: bit0 first, bit1 WAW
    logic [SEQ_W-1:0] lw_reg, lr_reg, wdat_reg;
    logic [CNT_W-1:0] hq_reg;
    logic [HIDX_W-1:0] hidx_reg;
    logic [SLOT_W-1:0] clr_reg;
    logic [HIDX_W-1:0] hclr_reg;
    logic             ov_reg;
    logic [CNT_W-1:0] od_reg;

    logic [SLOT_W-1:0] slot;
    logic              is_src;
    logic [SEQ_W-1:0]  earlier, span;
    logic [1:0]        kind;
    logic [SEQ_W-1:0]  seq_inc;

    assign is_src = (step_reg < 3'd4);
    assign slot   = is_src ? op_reg.src[step_reg[1:0]] : op_reg.dst[step_reg[0]];
    assign seq_inc = seq_reg + SEQ_W'(1);

    // Choose the pending distance
    always_comb
    begin
        if (is_src)
        begin
            earlier = lw_reg;
            kind    = KIND_RAW;
        end
        else if (pend_reg[0])
        begin
            earlier = lr_reg;
            kind    = KIND_WAR;
        end
        else
        begin
            earlier = lw_reg;
            kind    = KIND_WAW;
        end
        span = seq_reg - earlier;
    end

    assign op_ready     = (state_reg == S_IDLE) && !ov_reg;
    assign out_ch.valid = ov_reg;
    assign out_ch.data.bin_count = od_reg;

    // Memory ports
    always_ff @(posedge clk)
    begin
        if (state_reg == S_CLEAR)
        begin
            wr_mem[clr_reg] <= '0;
            rd_mem[clr_reg] <= '0;
            h_mem[hclr_reg] <= '0;
        end
        else
        begin
            if (state_reg == S_HRD)
            begin
                lw_reg <= wr_mem[slot];
                lr_reg <= rd_mem[slot];
            end
            if (state_reg == S_HUPD)
            begin
                if (is_src) rd_mem[slot] <= seq_reg;
                else        wr_mem[slot] <= seq_reg;
            end
            // bin index is settled once S_BRD has registered it
            if (state_reg == S_BWAIT || state_reg == S_RRD)
            begin
                hq_reg <= h_mem[hidx_reg];
            end
            if (state_reg == S_BWR && hq_reg != '1)
            begin
                h_mem[hidx_reg] <= hq_reg + CNT_W'(1);
            end
        end
    end

    // Sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            seq_reg   <= SEQ_W'(1);
            clr_reg   <= '0;
            hclr_reg  <= '0;
            step_reg  <= '0;
            pend_reg  <= '0;
            ov_reg    <= 1'b0;
            od_reg    <= '0;
            hidx_reg  <= '0;
            op_reg    <= '0;
            wdat_reg  <= '0;
        end
        else
        begin
            if (ov_reg && out_ch.ready) ov_reg <= 1'b0;
            unique case (state_reg)
                S_CLEAR:
                begin
                    if (clr_reg != SLOT_W'(NUM_REGS - 1)) clr_reg <= clr_reg + SLOT_W'(1);
                    if (hclr_reg != HIDX_W'(3*NUM_BINS - 1)) hclr_reg <= hclr_reg + HIDX_W'(1);
                    if (clr_reg == SLOT_W'(NUM_REGS - 1) &&
                        hclr_reg == HIDX_W'(3*NUM_BINS - 1))
                        state_reg <= S_IDLE;
                end
                S_IDLE:
                begin
                    if (op_valid && op_ready)
                    begin
                        op_reg <= op_data;
                        if (op_data.is_read)
                        begin
                            hidx_reg <= HIDX_W'(op_data.kind) * HIDX_W'(NUM_BINS)
                                      + HIDX_W'(op_data.bin);
                            state_reg <= op_data.kind_bad ? S_RDONE : S_RRD;
                        end
                        else
                        begin
                            step_reg  <= 3'd0;
                            state_reg <= S_NEXT;
                        end
                    end
                end
                S_NEXT:
                begin
                    // Skip to the next valid slot, or finish
                    if (step_reg < 3'd4 && step_reg < op_reg.nsrc)
                        state_reg <= S_HRD;
                    else if (step_reg < 3'd4)
                        step_reg <= 3'd4;
                    else if ((step_reg - 3'd4) < 3'(op_reg.ndst))
                        state_reg <= S_HRD;
                    else
                    begin
                        seq_reg   <= (seq_inc == '0) ? SEQ_W'(1) : seq_inc;
                        state_reg <= S_IDLE;
                    end
                end
                S_HRD:   state_reg <= S_HWAIT;
                S_HWAIT:
                begin
                    pend_reg <= is_src ? {1'b0, (lw_reg != '0)}
                                       : {(lw_reg != '0), (lr_reg != '0)};
                    state_reg <= S_BRD;
                end
                S_BRD:
                begin
                    if (pend_reg == 2'b00)
                        state_reg <= S_HUPD;
                    else
                    begin
                        hidx_reg <= HIDX_W'(kind) * HIDX_W'(NUM_BINS) +
                                    ((span < SEQ_W'(NUM_BINS - 1)) ?
                                     HIDX_W'(span[NB_W-1:0]) : HIDX_W'(NUM_BINS - 1));
                        state_reg <= S_BWAIT;
                    end
                end
                S_BWAIT: state_reg <= S_BWR;
                S_BWR:
                begin
                    if (pend_reg[0]) pend_reg[0] <= 1'b0;
                    else             pend_reg[1] <= 1'b0;
                    state_reg <= S_BRD;
                end
                S_HUPD:
                begin
                    wdat_reg  <= seq_reg;
                    step_reg  <= step_reg + 3'd1;
                    state_reg <= S_NEXT;
                end
                S_RRD:   state_reg <= S_RWAIT;
                S_RWAIT:
                begin
                    od_reg    <= hq_reg;
                    ov_reg    <= 1'b1;
                    state_reg <= S_IDLE;
                end
                S_RDONE:
                begin
                    od_reg    <= '0;
                    ov_reg    <= 1'b1;
                    state_reg <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    logic unused_w;
    assign unused_w = ^wdat_reg;
endmodule

// File: hw/rtl/register_dependency_distance_profiler_unit.sv
// Top level of the register dependency distance profiler.
// Depends on rddp_pkg, rddp_stream_if, rddp_front, rddp_queue, rddp_back.
//
//  channel   dir  payload      transfer when
//  in_ch     in   in_item_t    valid && ready
//  out_ch    out  out_item_t   valid && ready
//
// A record holds the back-end sequencer for S_IDLE, a finishing S_NEXT, a skip S_NEXT when
// fewer than four sources are given, S_NEXT, S_HRD, S_HWAIT, S_BRD and S_HUPD per register
// id, and S_BWAIT, S_BWR and S_BRD per distance counted (sources up to one, destinations
// up to two), set by the single-port memories. A read is offered after S_RRD and S_RWAIT
// (a bad kind after S_RDONE alone); the next item is taken only once that result has
// transferred. After reset a clearing pass over the larger of 256 and 192 entries runs
// before the back end takes its first item. Input stalls while the 2-entry queue is full.
module register_dependency_distance_profiler_unit (
    input  logic          clk,
    input  logic          rst_n,
    rddp_stream_if.sink   in_ch,
    rddp_stream_if.source out_ch
);
    import rddp_pkg::*;

    logic f_valid, f_ready, q_valid, q_ready;
    op_t  f_data, q_data;

    rddp_front u_front (
        .clk(clk), .rst_n(rst_n), .in_ch(in_ch),
        .op_valid(f_valid), .op_data(f_data), .op_ready(f_ready)
    );

    rddp_queue u_queue (
        .clk(clk), .rst_n(rst_n),
        .wr_valid(f_valid), .wr_data(f_data), .wr_ready(f_ready),
        .rd_valid(q_valid), .rd_data(q_data), .rd_ready(q_ready)
    );

    rddp_back u_back (
        .clk(clk), .rst_n(rst_n),
        .op_valid(q_valid), .op_data(q_data), .op_ready(q_ready),
        .out_ch(out_ch)
    );
endmodule

// File: tb/sv/testbench.sv
// Self-checking testbench for register_dependency_distance_profiler_unit.
// Depends on rddp_pkg, rddp_stream_if and the profiler RTL; predicts every histogram
// read from its own copy of the history tables and compares the bin counts returned.
module testbench;
    import rddp_pkg::*;

    logic clk;
    logic rst_n;

    rddp_stream_if #(.payload_t(in_item_t))  in_ch ();
    rddp_stream_if #(.payload_t(out_item_t)) out_ch ();

    register_dependency_distance_profiler_unit uut (
        .clk   (clk),
        .rst_n (rst_n),
        .in_ch (in_ch.sink),
        .out_ch(out_ch.source)
    );

    // Predictor state
    logic [SEQ_W-1:0] pred_seq;
    logic [SEQ_W-1:0] pred_last_wr [NUM_REGS];
    logic [SEQ_W-1:0] pred_last_rd [NUM_REGS];
    logic [CNT_W-1:0] pred_hist [3*NUM_BINS];

    logic [CNT_W-1:0] expected_counts [$];
    int mismatches;
    int reads_checked;
    int records_sent;
    int hold_off;       // cycles the receiver must hold off, set by the pressure test
    bit sender_bursty;

    initial clk = 1'b0;
    always #2 clk = ~clk;

    // Add one distance to a histogram, saturating
    function automatic void bump_bin(logic [1:0] kind, logic [SEQ_W-1:0] earlier);
        logic [SEQ_W-1:0] span;
        int bin;
        int idx;
        span = pred_seq - earlier;
        bin  = (span < NUM_BINS - 1) ? int'(span) : NUM_BINS - 1;
        idx  = int'(kind) * NUM_BINS + bin;
        if (pred_hist[idx] != 32'hFFFF_FFFF)
            pred_hist[idx] = pred_hist[idx] + 1;
    endfunction

    // Apply one accepted item to the predictor
    function automatic void predict_item(in_item_t it);
        int ns;
        int nd;
        int r;
        logic [REG_W-1:0] srcs [4];
        logic [REG_W-1:0] dsts [2];
        int b;
        if (it.cmd == CMD_READ)
        begin
            if (it.hist_kind > KIND_WAW)
                expected_counts.push_back('0);
            else
            begin
                b = (it.hist_bin > NUM_BINS - 1) ? NUM_BINS - 1 : int'(it.hist_bin);
                expected_counts.push_back(pred_hist[int'(it.hist_kind) * NUM_BINS + b]);
            end
            return;
        end
        srcs = '{it.src_reg_0, it.src_reg_1, it.src_reg_2, it.src_reg_3};
        dsts = '{it.dst_reg_0, it.dst_reg_1};
        ns = (it.src_count > SMAX) ? SMAX : int'(it.src_count);
        nd = (it.dst_count > DMAX) ? DMAX : int'(it.dst_count);
        for (int i = 0; i < ns; i++)
        begin
            r = int'(srcs[i]) % NUM_REGS;
            if (pred_last_wr[r] != 0)
                bump_bin(KIND_RAW, pred_last_wr[r]);
            pred_last_rd[r] = pred_seq;
        end
        for (int i = 0; i < nd; i++)
        begin
            r = int'(dsts[i]) % NUM_REGS;
            if (pred_last_rd[r] != 0)
                bump_bin(KIND_WAR, pred_last_rd[r]);
            if (pred_last_wr[r] != 0)
                bump_bin(KIND_WAW, pred_last_wr[r]);
            pred_last_wr[r] = pred_seq;
        end
        pred_seq = pred_seq + 1;
        if (pred_seq == 0)
            pred_seq = 1;
    endfunction

    // Send one item; inputs change on the falling edge, transfer seen at the rising edge
    task automatic send_item(in_item_t it);
        int gap;
        if (sender_bursty && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 6);
            in_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_ch.data  <= it;
        in_ch.valid <= 1'b1;
        do
            @(posedge clk);
        while (!in_ch.ready);
        predict_item(it);
        if (it.cmd == CMD_RECORD)
            records_sent++;
        @(negedge clk);
    endtask

    task automatic idle_input();
        in_ch.valid <= 1'b0;
        in_ch.data  <= '0;
    endtask

    function automatic in_item_t make_record(int ns, int nd, logic [REG_W-1:0] s0,
                                             logic [REG_W-1:0] s1, logic [REG_W-1:0] s2,
                                             logic [REG_W-1:0] s3, logic [REG_W-1:0] d0,
                                             logic [REG_W-1:0] d1);
        in_item_t it;
        logic [63:0] rnd;
        rnd = {$urandom, $urandom};
        it = rnd[$bits(in_item_t)-1:0];
        it.cmd = CMD_RECORD;
        it.src_count = ns[2:0];
        it.dst_count = nd[1:0];
        it.src_reg_0 = s0;
        it.src_reg_1 = s1;
        it.src_reg_2 = s2;
        it.src_reg_3 = s3;
        it.dst_reg_0 = d0;
        it.dst_reg_1 = d1;
        return it;
    endfunction

    function automatic in_item_t make_read(logic [1:0] kind, logic [BIN_W-1:0] bin);
        in_item_t it;
        logic [63:0] rnd;
        rnd = {$urandom, $urandom};
        it = rnd[$bits(in_item_t)-1:0];
        it.cmd = CMD_READ;
        it.hist_kind = kind;
        it.hist_bin = bin;
        return it;
    endfunction

    // Random register id, mostly from a small pool so that short distances occur
    function automatic logic [REG_W-1:0] pick_reg();
        if ($urandom_range(0, 9) < 7)
            return REG_W'($urandom_range(0, 11));
        return REG_W'($urandom);
    endfunction

    function automatic in_item_t random_item();
        in_item_t it;
        if ($urandom_range(0, 4) == 0)
        begin
            it = make_read(2'($urandom_range(0, 3)), BIN_W'($urandom));
            if ($urandom_range(0, 1) == 0)
                it.hist_bin = BIN_W'($urandom_range(0, 5));
        end
        else
        begin
            it = make_record($urandom_range(0, 7), $urandom_range(0, 3), pick_reg(),
                             pick_reg(), pick_reg(), pick_reg(), pick_reg(), pick_reg());
            // most records stay in the legal count range
            if ($urandom_range(0, 9) != 0)
            begin
                it.src_count = 3'($urandom_range(0, 4));
                it.dst_count = 2'($urandom_range(0, 2));
            end
        end
        return it;
    endfunction

    // Result checker
    always @(posedge clk)
    begin
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            if (expected_counts.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: unexpected result bin_count=%0d", out_ch.data.bin_count);
            end
            else
            begin
                logic [CNT_W-1:0] want;
                want = expected_counts.pop_front();
                reads_checked++;
                if (out_ch.data.bin_count !== want)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("ERROR: bin_count expected %0d got %0d", want,
                                 out_ch.data.bin_count);
                end
            end
        end
    end

    // Receiver stall pattern, with a long hold-off when requested
    always @(negedge clk)
    begin
        if (hold_off > 0)
        begin
            out_ch.ready <= 1'b0;
            hold_off <= hold_off - 1;
        end
        else
            out_ch.ready <= ($urandom_range(0, 3) != 0);
    end

    task automatic drain();
        int guard;
        idle_input();
        guard = 0;
        while (expected_counts.size() != 0 && guard < 20000)
        begin
            @(negedge clk);
            guard++;
        end
        repeat (40) @(negedge clk);
    endtask

    // Directed: reads of bins that were never hit, kind out of range, bin extremes
    task automatic test_reads_after_reset();
        send_item(make_read(KIND_RAW, '0));
        send_item(make_read(KIND_WAW, '1));
        send_item(make_read(2'd3, 6'd5));
        send_item(make_read(KIND_WAR, 6'd63));
    endtask

    // Directed: same-instruction reuse, distances, id extremes, counts too large
    task automatic test_dependency_cases();
        send_item(make_record(2, 2, 8'd0, 8'd0, 8'd0, 8'd0, 8'd255, 8'd255));
        send_item(make_record(4, 2, 8'd255, 8'd0, 8'd255, 8'd0, 8'd0, 8'd1));
        send_item(make_record(7, 3, 8'd1, 8'd170, 8'd85, 8'd255, 8'd1, 8'd0));
        send_item(make_record(0, 0, 8'd9, 8'd9, 8'd9, 8'd9, 8'd9, 8'd9));
        send_item(make_record(1, 1, 8'd170, 8'd0, 8'd0, 8'd0, 8'd85, 8'd0));
        send_item(make_record(5, 0, 8'd85, 8'd170, 8'd1, 8'd0, 8'd0, 8'd0));
        for (int b = 0; b < 6; b++)
            send_item(make_read(KIND_RAW, 6'(b)));
        send_item(make_read(KIND_WAR, 6'd0));
        send_item(make_read(KIND_WAR, 6'd1));
        send_item(make_read(KIND_WAW, 6'd0));
        send_item(make_read(KIND_WAW, 6'd2));
        drain();
    endtask

    // Directed: a distance past the last bin lands in the last bin
    task automatic test_far_distance();
        send_item(make_record(0, 1, 8'd0, 8'd0, 8'd0, 8'd0, 8'd200, 8'd0));
        for (int i = 0; i < 70; i++)
            send_item(make_record(0, 0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0));
        send_item(make_record(1, 1, 8'd200, 8'd0, 8'd0, 8'd0, 8'd200, 8'd0));
        send_item(make_read(KIND_RAW, 6'd63));
        send_item(make_read(KIND_WAW, 6'd63));
        drain();
    endtask

    // Receiver holds off for a long time while the sender keeps going
    task automatic test_backpressure();
        hold_off = 400;
        for (int i = 0; i < 40; i++)
            send_item(make_read(2'($urandom_range(0, 2)), BIN_W'($urandom_range(0, 3))));
        drain();
    endtask

    task automatic test_random_traffic(int n);
        sender_bursty = 1'b1;
        for (int i = 0; i < n; i++)
        begin
            if ((i % 200) < 40)
                sender_bursty = 1'b0;
            else
                sender_bursty = 1'b1;
            send_item(random_item());
        end
        // final sweep over every seventh bin of each of the three histograms
        for (int k = 0; k < 3; k++)
            for (int b = 0; b < NUM_BINS; b += 7)
                send_item(make_read(2'(k), 6'(b)));
        drain();
    endtask

    initial
    begin
        rst_n = 1'b0;
        in_ch.valid = 1'b0;
        in_ch.data = '0;
        out_ch.ready = 1'b0;
        hold_off = 0;
        mismatches = 0;
        reads_checked = 0;
        records_sent = 0;
        sender_bursty = 1'b0;
        pred_seq = 1;
        for (int i = 0; i < NUM_REGS; i++)
        begin
            pred_last_wr[i] = '0;
            pred_last_rd[i] = '0;
        end
        for (int i = 0; i < 3 * NUM_BINS; i++)
            pred_hist[i] = '0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_reads_after_reset();
        test_dependency_cases();
        test_far_distance();
        test_backpressure();
        test_random_traffic(900);

        $display("Run covered %0d records and %0d checked bin reads,", records_sent,
                 reads_checked);
        $display("including reuse, far distances, bad kinds and a long output stall.");
        if (mismatches == 0 && expected_counts.size() == 0)
            $display("*** PASSED ***");
        else
        begin
            $display("%0d mismatches, %0d results missing", mismatches,
                     expected_counts.size());
            $display("*** FAILED ***");
        end
        $finish;
    end

    // Watchdog
    initial
    begin
        #2000000;
        $display("Timeout");
        $display("*** FAILED ***");
        $finish;
    end
endmodule
